[sv/nt_pkg.sv]
// shared constants, codes and control types for the name table
package nt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BYTES   = 8;

  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int USED_W = 5;
  localparam int NAME_W = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_LAST,
    S_MOVE,
    S_DONE,
    S_MISS,
    S_FULL
  } state_t;

  typedef struct packed {
    logic    load;
    logic    insert;
    logic    scan_step;
    logic    rd_last;
    logic    move;
    logic    respond;
    status_t status;
  } ctl_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic empty;
    logic full;
  } sts_t;

endpackage

[sv/name_table_insert_search_delete.sv]
// name table: insert appends, search finds first match, delete swaps in last entry
// insert steps through S_INS and S_DONE; refused insert: S_FULL, unused kind: S_MISS
// search: scans from slot 0 to the first match or the last entry; empty table: S_MISS
// delete: search, then S_LAST reads the last entry and S_MOVE moves it into the hole
// busy drops in the cycle out_strobe is high, so a new word is taken right away
// synchronous active-low reset empties the table; store contents are left as they are
module name_table_insert_search_delete (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [nt_pkg::KIND_W-1:0]   in_kind,
  input  logic [nt_pkg::NAME_W-1:0]   in_key_name,
  output logic                        out_strobe,
  output logic [nt_pkg::STAT_W-1:0]   out_status,
  output logic [nt_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [nt_pkg::USED_W-1:0]   out_entries_used
);

  nt_pkg::ctl_t ctl;
  nt_pkg::sts_t sts;

  nt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (nt_pkg::kind_t'(in_kind)),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  nt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .key_name         (in_key_name),
    .ctl              (ctl),
    .sts              (sts),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_entries_used (out_entries_used)
  );

endmodule

[sv/nt_ctrl.sv]
// request sequencer for the name table
module nt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  nt_pkg::kind_t   kind,
  input  nt_pkg::sts_t    sts,
  output nt_pkg::ctl_t    ctl,
  output logic            busy
);

  nt_pkg::state_t state_r, state_nxt;
  nt_pkg::kind_t  kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nt_pkg::S_IDLE;
      kind_r  <= nt_pkg::KIND_NONE;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    case (state_r)
      nt_pkg::S_IDLE: begin
        if (start) begin
          kind_nxt = kind;
          case (kind)
            nt_pkg::KIND_INSERT: state_nxt = sts.full ? nt_pkg::S_FULL : nt_pkg::S_INS;
            nt_pkg::KIND_DELETE,
            nt_pkg::KIND_SEARCH: state_nxt = sts.empty ? nt_pkg::S_MISS : nt_pkg::S_SCAN;
            default:             state_nxt = nt_pkg::S_MISS;
          endcase
        end
      end
      nt_pkg::S_INS: state_nxt = nt_pkg::S_DONE;
      nt_pkg::S_SCAN: begin
        if (sts.hit) begin
          state_nxt = (kind_r == nt_pkg::KIND_DELETE) ? nt_pkg::S_LAST : nt_pkg::S_DONE;
        end else if (sts.last) begin
          state_nxt = nt_pkg::S_MISS;
        end
      end
      nt_pkg::S_LAST: state_nxt = nt_pkg::S_MOVE;
      nt_pkg::S_MOVE: state_nxt = nt_pkg::S_DONE;
      nt_pkg::S_DONE,
      nt_pkg::S_MISS,
      nt_pkg::S_FULL: state_nxt = nt_pkg::S_IDLE;
      default:        state_nxt = nt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.status = nt_pkg::ST_MISS;
    busy       = 1'b1;
    case (state_r)
      nt_pkg::S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      nt_pkg::S_INS:  ctl.insert = 1'b1;
      nt_pkg::S_SCAN: ctl.scan_step = !(sts.hit || sts.last);
      nt_pkg::S_LAST: ctl.rd_last = 1'b1;
      nt_pkg::S_MOVE: ctl.move = 1'b1;
      nt_pkg::S_DONE: begin
        ctl.respond = 1'b1;
        ctl.status  = nt_pkg::ST_DONE;
      end
      nt_pkg::S_MISS: begin
        ctl.respond = 1'b1;
        ctl.status  = nt_pkg::ST_MISS;
      end
      nt_pkg::S_FULL: begin
        ctl.respond = 1'b1;
        ctl.status  = nt_pkg::ST_FULL;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

[sv/nt_dp.sv]
// key store, scan pointer, entry count and result registers
module nt_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [nt_pkg::NAME_W-1:0]   key_name,
  input  nt_pkg::ctl_t                ctl,
  output nt_pkg::sts_t                sts,
  output logic                        out_strobe,
  output logic [nt_pkg::STAT_W-1:0]   out_status,
  output logic [nt_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [nt_pkg::USED_W-1:0]   out_entries_used
);

  logic [nt_pkg::KEY_W-1:0] mem [nt_pkg::TABLE_DEPTH];

  logic [nt_pkg::KEY_W-1:0]  key_r;
  logic [nt_pkg::KEY_W-1:0]  rd_data_r;
  logic [nt_pkg::IDX_W-1:0]  idx_r;
  logic [nt_pkg::IDX_W-1:0]  cmp_idx_r;
  logic                      cmp_vld_r;
  logic [nt_pkg::IDX_W-1:0]  slot_r;
  logic [nt_pkg::CNT_W-1:0]  count_r;
  logic                      strobe_r;
  logic [nt_pkg::STAT_W-1:0] status_r;
  logic [nt_pkg::SLOT_W-1:0] oslot_r;
  logic [nt_pkg::USED_W-1:0] oused_r;

  logic [nt_pkg::CNT_W-1:0]  last_w;
  logic [nt_pkg::IDX_W-1:0]  rd_addr;
  logic                      hit;

  assign last_w  = count_r - nt_pkg::CNT_W'(1);
  assign rd_addr = ctl.rd_last ? last_w[nt_pkg::IDX_W-1:0] : idx_r;
  assign hit     = cmp_vld_r && (rd_data_r == key_r);

  assign sts.hit   = hit;
  assign sts.last  = cmp_vld_r && (nt_pkg::CNT_W'(cmp_idx_r) == last_w);
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == nt_pkg::CNT_W'(nt_pkg::TABLE_DEPTH));

  // key store
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (ctl.insert) begin
      mem[count_r[nt_pkg::IDX_W-1:0]] <= key_r;
    end else if (ctl.move) begin
      mem[slot_r] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= key_name[nt_pkg::KEY_W-1:0];
    end
    if (ctl.load) begin
      idx_r <= '0;
    end else if (ctl.scan_step) begin
      idx_r <= idx_r + nt_pkg::IDX_W'(1);
    end
    cmp_idx_r <= idx_r;
    if (hit) begin
      slot_r <= cmp_idx_r;
    end else if (ctl.insert) begin
      slot_r <= count_r[nt_pkg::IDX_W-1:0];
    end
    status_r <= ctl.status;
    oslot_r  <= (ctl.status == nt_pkg::ST_DONE) ? nt_pkg::SLOT_W'(slot_r) : '0;
    oused_r  <= nt_pkg::USED_W'(count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      cmp_vld_r <= ctl.scan_step;
      strobe_r  <= ctl.respond;
      if (ctl.insert) begin
        count_r <= count_r + nt_pkg::CNT_W'(1);
      end else if (ctl.move) begin
        count_r <= last_w;
      end
    end
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_slot_index   = oslot_r;
  assign out_entries_used = oused_r;

endmodule

[sv/nt_chk.sv]
// port checker for the name table and its bind
module nt_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [nt_pkg::STAT_W-1:0]   out_status,
  input logic [nt_pkg::SLOT_W-1:0]   out_slot_index,
  input logic [nt_pkg::USED_W-1:0]   out_entries_used
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held two cycles");

  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != nt_pkg::ST_DONE) |-> out_slot_index == '0)
    else $error("nonzero slot on failed request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == nt_pkg::ST_FULL)
      |-> out_entries_used == nt_pkg::USED_W'(nt_pkg::TABLE_DEPTH))
    else $error("full status with table not full");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == nt_pkg::ST_DONE) || (out_status == nt_pkg::ST_MISS)
      || (out_status == nt_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind name_table_insert_search_delete nt_chk u_nt_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_status       (out_status),
  .out_slot_index   (out_slot_index),
  .out_entries_used (out_entries_used)
);

[tb/name_table_insert_search_delete_test.sv]
// self-checking testbench for the name table: shadow table predicts every reply word
`timescale 1ns / 1ps

module name_table_insert_search_delete_test;
  import nt_pkg::*;

  typedef struct {
    kind_t             kind;
    logic [NAME_W-1:0] key;
    bit                drain;
  } request_t;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [USED_W-1:0] used;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] in_kind = KIND_INSERT;
  logic [NAME_W-1:0] in_key_name = '0;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot_index;
  logic [USED_W-1:0] out_entries_used;

  request_t          req_q[$];
  reply_t            reply_q[$];
  request_t          cur_req;
  reply_t            next_reply;
  reply_t            got_reply;

  logic [KEY_W-1:0]  shadow_keys[TABLE_DEPTH];
  int                shadow_used = 0;

  int                err_cnt = 0;
  int                sent_cnt = 0;
  int                reply_cnt = 0;
  int                n_insert = 0;
  int                n_delete = 0;
  int                n_search = 0;
  int                n_other = 0;
  int                n_hit = 0;
  int                n_full = 0;

  logic [NAME_W-1:0] key_pool[6];

  name_table_insert_search_delete i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_key_name      (in_key_name),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_entries_used (out_entries_used)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic reply_t table_apply(kind_t kind, logic [NAME_W-1:0] key_in);
    reply_t           r;
    logic [KEY_W-1:0] k;
    int               hit;
    int               i;
    k = key_in[KEY_W-1:0];
    r.status = ST_MISS;
    r.slot = '0;
    hit = TABLE_DEPTH;
    for (i = 0; i < shadow_used; i++) begin
      if (shadow_keys[i] == k) begin
        hit = i;
        break;
      end
    end
    case (kind)
      KIND_INSERT: begin
        n_insert++;
        if (shadow_used >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          r.slot = SLOT_W'(shadow_used);
          shadow_keys[shadow_used] = k;
          shadow_used++;
          r.status = ST_DONE;
        end
      end
      KIND_DELETE: begin
        n_delete++;
        if (hit < TABLE_DEPTH) begin
          shadow_keys[hit] = shadow_keys[shadow_used-1];
          shadow_used--;
          r.slot = SLOT_W'(hit);
          r.status = ST_DONE;
          n_hit++;
        end
      end
      KIND_SEARCH: begin
        n_search++;
        if (hit < TABLE_DEPTH) begin
          r.slot = SLOT_W'(hit);
          r.status = ST_DONE;
          n_hit++;
        end
      end
      default: begin
        n_other++;
      end
    endcase
    r.used = USED_W'(shadow_used);
    return r;
  endfunction

  task automatic add_req(kind_t kind, logic [NAME_W-1:0] key, bit drain);
    request_t q;
    q.kind = kind;
    q.key = key;
    q.drain = drain;
    req_q.push_back(q);
  endtask

  function automatic logic [NAME_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        next_reply = table_apply(cur_req.kind, cur_req.key);
        reply_q.push_back(next_reply);
        sent_cnt++;
      end
      if (!start || !busy) begin
        if (req_q.size() == 0 || (req_q[0].drain && reply_q.size() != 0) ||
            (!(sent_cnt >= 600 && sent_cnt < 800) && $urandom_range(99) < 17)) begin
          start <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          start <= 1'b1;
          in_kind <= cur_req.kind;
          in_key_name <= cur_req.key;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      reply_cnt++;
      if (reply_q.size() == 0) begin
        $error("reply word with nothing expected");
        err_cnt++;
      end else begin
        got_reply = reply_q.pop_front();
        if (out_status !== got_reply.status) begin
          $error("status: expected %0d, actual %0d", got_reply.status, out_status);
          err_cnt++;
        end
        if (out_slot_index !== got_reply.slot) begin
          $error("slot_index: expected %0d, actual %0d", got_reply.slot, out_slot_index);
          err_cnt++;
        end
        if (out_entries_used !== got_reply.used) begin
          $error("entries_used: expected %0d, actual %0d", got_reply.used,
                 out_entries_used);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int          i;
    int          blk;
    int          pct;
    int          bias;
    kind_t       kind;
    logic [NAME_W-1:0] key;

    // directed words
    add_req(KIND_SEARCH, '0, 1'b0);
    add_req(KIND_DELETE, '0, 1'b0);
    add_req(KIND_NONE, '0, 1'b0);
    add_req(KIND_INSERT, '0, 1'b0);
    add_req(KIND_INSERT, '1, 1'b0);
    add_req(KIND_INSERT, '1, 1'b0);
    for (i = 3; i < TABLE_DEPTH; i++)
      add_req(KIND_INSERT, 64'h1 << (i * 4), 1'b0);
    add_req(KIND_INSERT, 64'h0123_4567_89ab_cdef, 1'b0);
    add_req(KIND_SEARCH, '1, 1'b0);
    add_req(KIND_DELETE, '0, 1'b0);
    add_req(KIND_DELETE, 64'h1 << 56, 1'b0);
    add_req(KIND_SEARCH, 64'h1 << 60, 1'b0);
    add_req(KIND_NONE, '1, 1'b0);

    // random words from a small key pool so hits are common
    for (i = 0; i < 6; i++)
      key_pool[i] = rand_key();
    for (blk = 0; blk < 29; blk++) begin
      bias = blk % 3;
      key_pool[$urandom_range(5)] = rand_key();
      key_pool[1] = {key_pool[1][63:32], key_pool[0][31:0]};
      key_pool[2] = key_pool[0] ^ (64'h1 << $urandom_range(63));
      for (i = 0; i < 50; i++) begin
        pct = $urandom_range(99);
        if (pct < 3)
          kind = KIND_NONE;
        else if (pct < (bias == 0 ? 63 : bias == 1 ? 43 : 25))
          kind = KIND_INSERT;
        else if (pct < (bias == 0 ? 78 : bias == 1 ? 68 : 70))
          kind = KIND_DELETE;
        else
          kind = KIND_SEARCH;
        key = ($urandom_range(99) < 10) ? rand_key() : key_pool[$urandom_range(5)];
        add_req(kind, key, (i == 0) && (blk % 6 == 0));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || start)
      @(posedge clk);
    while (reply_q.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d words, %0d replies: %0d inserts (%0d refused full), %0d deletes,",
             sent_cnt, reply_cnt, n_insert, n_full, n_delete);
    $display("  %0d searches, %0d matches on delete or search, %0d unused kind",
             n_search, n_hit, n_other);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
sv/nt_pkg.sv
sv/nt_ctrl.sv
sv/nt_dp.sv
sv/name_table_insert_search_delete.sv
sv/nt_chk.sv
tb/name_table_insert_search_delete_test.sv
